>>> design/bounded_deque_with_dump_assert.svh
// Assertion macros for the bounded deque block.
`ifndef BOUNDED_DEQUE_WITH_DUMP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_DUMP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BDQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BDQ_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) cond |=> prop) else $error(msg);
`else
`define BDQ_ASSERT(lbl, clk, rstn, prop, msg)
`define BDQ_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)
`endif
`endif

>>> design/bdq_pkg.sv
// Types and codes shared by the deque cells and the deque controller.
package bdq_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned OpW     = 3;
    localparam int unsigned StatusW = 2;

    localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OpW-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OpW-1:0] OP_DUMP       = 3'd4;

    localparam logic [StatusW-1:0] ST_OK    = 2'd0;
    localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

    typedef enum logic [5:0] {
        CMD_HOLD       = 6'b000001,
        CMD_PUSH_FRONT = 6'b000010,
        CMD_PUSH_BACK  = 6'b000100,
        CMD_POP_FRONT  = 6'b001000,
        CMD_POP_BACK   = 6'b010000,
        CMD_ROTATE     = 6'b100000
    } t_cmd;

    typedef struct packed {
        t_cmd                    cmd;
        logic signed [DataW-1:0] value;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } t_state;

endpackage

>>> design/bdq_cell.sv
// One storage cell of the deque chain; it trades data with its two neighbors.
module bdq_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bdq_pkg::t_cell_ctl                  i_ctl,
    input  logic                                i_prev_valid,
    input  logic signed [bdq_pkg::DataW-1:0]    i_prev_data,
    input  logic                                i_next_valid,
    input  logic signed [bdq_pkg::DataW-1:0]    i_next_data,
    input  logic signed [bdq_pkg::DataW-1:0]    i_head_data,
    output logic                                o_valid,
    output logic signed [bdq_pkg::DataW-1:0]    o_data,
    output logic signed [bdq_pkg::DataW-1:0]    o_tail_data
);
    import bdq_pkg::*;

    logic                    r_valid;
    logic                    n_valid;
    logic signed [DataW-1:0] r_data;
    logic signed [DataW-1:0] n_data;
    logic                    is_tail;

    assign is_tail = r_valid && !i_next_valid;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        case (i_ctl.cmd)
            CMD_PUSH_FRONT: begin
                n_valid = i_prev_valid;
                n_data  = i_prev_data;
            end
            CMD_PUSH_BACK: begin
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_data  = i_ctl.value;
                end
            end
            CMD_POP_FRONT: begin
                n_valid = i_next_valid;
                n_data  = i_next_data;
            end
            CMD_POP_BACK: begin
                if (is_tail) begin
                    n_valid = 1'b0;
                end
            end
            CMD_ROTATE: begin
                // The tail takes the head entry; the others move one step forward.
                if (is_tail) begin
                    n_data = i_head_data;
                end else if (r_valid) begin
                    n_data = i_next_data;
                end
            end
            default: begin
                n_valid = r_valid;
                n_data  = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_tail_data = is_tail ? r_data : '0;

endmodule

>>> design/bounded_deque_with_dump.sv
// Top level of the bounded double-ended queue: controller and chain of cells.
//
// Input channel: i_valid, o_stall, i_operation, i_value. A request is taken
// when i_valid is high and o_stall is low. Operations: push front, push back,
// pop front, pop back and dump; other codes are dropped without a result.
// Output channel: o_valid, i_stall, o_value_res, o_status, o_last, held in an
// output register until the receiver takes it (o_valid high, i_stall low).
// The front entry always sits in the first cell; the back entry is found by
// its cell and registered each cycle, so every request first waits in the
// execute state. Push and pop: the result is registered as the execute state
// ends; no new request is taken before that. Dump of N entries: N results,
// one per cycle while the receiver does not stall, as the chain rotates once
// around; no new request is taken before the last result. A dump of an empty
// queue gives a single result with status empty. While the receiver stalls,
// the block finishes at most one pending request into the output register
// and then waits; o_stall is high while a taken request waits.
// Reset empties the queue and clears the output valid.
module bounded_deque_with_dump #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bdq_pkg::OpW-1:0]              i_operation,
    input  logic signed [bdq_pkg::DataW-1:0]     i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [bdq_pkg::DataW-1:0]     o_value_res,
    output logic [bdq_pkg::StatusW-1:0]          o_status,
    output logic                                 o_last
);
    import bdq_pkg::*;

    localparam int unsigned CntW = $clog2(CAPACITY + 1);
    localparam logic [CntW-1:0] CntOne = CntW'(1);
    localparam logic [CntW-1:0] CntCap = CntW'(CAPACITY);

    t_state                  r_state;
    t_state                  n_state;
    logic [OpW-1:0]          r_op;
    logic signed [DataW-1:0] r_val;
    logic [CntW-1:0]         r_count;
    logic [CntW-1:0]         n_count;
    logic [CntW-1:0]         r_idx;
    logic [CntW-1:0]         n_idx;
    logic signed [DataW-1:0] r_tail;
    logic signed [DataW-1:0] n_tail;

    logic                    r_ovalid;
    logic                    n_ovalid;
    logic signed [DataW-1:0] r_ovalue;
    logic signed [DataW-1:0] n_ovalue;
    logic [StatusW-1:0]      r_ostatus;
    logic [StatusW-1:0]      n_ostatus;
    logic                    r_olast;
    logic                    n_olast;

    t_cell_ctl               cell_ctl;
    logic                    cell_valid [CAPACITY];
    logic signed [DataW-1:0] cell_data  [CAPACITY];
    logic signed [DataW-1:0] cell_tail  [CAPACITY];
    logic [CAPACITY-1:0]     valid_vec;

    logic                    in_take;
    logic                    out_free;
    logic                    is_full;
    logic                    is_empty;
    logic                    dump_last;

    assign in_take   = i_valid && !o_stall;
    assign out_free  = !r_ovalid || !i_stall;
    assign is_full   = (r_count == CntCap);
    assign is_empty  = (r_count == '0);
    assign dump_last = ((r_idx + CntOne) == r_count);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                    prev_valid;
            logic signed [DataW-1:0] prev_data;
            logic                    next_valid;
            logic signed [DataW-1:0] next_data;

            if (g == 0) begin : g_first
                // The first cell sees the pushed value as its predecessor.
                assign prev_valid = 1'b1;
                assign prev_data  = cell_ctl.value;
            end else begin : g_mid
                assign prev_valid = cell_valid[g-1];
                assign prev_data  = cell_data[g-1];
            end

            if (g == CAPACITY - 1) begin : g_end
                assign next_valid = 1'b0;
                assign next_data  = '0;
            end else begin : g_inner
                assign next_valid = cell_valid[g+1];
                assign next_data  = cell_data[g+1];
            end

            bdq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (cell_ctl),
                .i_prev_valid (prev_valid),
                .i_prev_data  (prev_data),
                .i_next_valid (next_valid),
                .i_next_data  (next_data),
                .i_head_data  (cell_data[0]),
                .o_valid      (cell_valid[g]),
                .o_data       (cell_data[g]),
                .o_tail_data  (cell_tail[g])
            );

            assign valid_vec[g] = cell_valid[g];
        end
    endgenerate

    // Only the back cell contributes, so an OR over all cells yields its entry.
    always_comb begin
        n_tail = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            n_tail = n_tail | cell_tail[k];
        end
    end

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_idx          = r_idx;
        n_ovalid       = r_ovalid && i_stall;
        n_ovalue       = r_ovalue;
        n_ostatus      = r_ostatus;
        n_olast        = r_olast;
        cell_ctl.cmd   = CMD_HOLD;
        cell_ctl.value = r_val;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state   = S_IDLE;
                    n_ovalue  = '0;
                    n_ostatus = ST_OK;
                    n_olast   = 1'b1;
                    case (r_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_ovalid = 1'b1;
                            if (is_full) begin
                                n_ostatus = ST_FULL;
                            end else begin
                                cell_ctl.cmd = (r_op == OP_PUSH_FRONT) ?
                                               CMD_PUSH_FRONT : CMD_PUSH_BACK;
                                n_count      = r_count + CntOne;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            n_ovalid = 1'b1;
                            if (is_empty) begin
                                n_ostatus = ST_EMPTY;
                            end else if (r_op == OP_POP_FRONT) begin
                                cell_ctl.cmd = CMD_POP_FRONT;
                                n_ovalue     = cell_data[0];
                                n_count      = r_count - CntOne;
                            end else begin
                                cell_ctl.cmd = CMD_POP_BACK;
                                n_ovalue     = r_tail;
                                n_count      = r_count - CntOne;
                            end
                        end
                        OP_DUMP: begin
                            if (is_empty) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_EMPTY;
                            end else begin
                                n_state = S_DUMP;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    // Emit the head and rotate; a full turn restores the order.
                    cell_ctl.cmd = CMD_ROTATE;
                    n_ovalid     = 1'b1;
                    n_ovalue     = cell_data[0];
                    n_ostatus    = ST_OK;
                    n_olast      = dump_last;
                    n_idx        = r_idx + CntOne;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= i_operation;
            r_val <= i_value;
        end
        r_tail    <= n_tail;
        r_ovalue  <= n_ovalue;
        r_ostatus <= n_ostatus;
        r_olast   <= n_olast;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_value_res = r_ovalue;
    assign o_status    = r_ostatus;
    assign o_last      = r_olast;

    `include "bounded_deque_with_dump_assert.svh"

    `BDQ_ASSERT(a_count_matches_cells, i_clk, i_rst_n, (CntW'($countones(valid_vec)) == r_count), "entry count disagrees with occupied cells")
    `BDQ_ASSERT(a_count_bounded, i_clk, i_rst_n, (r_count <= CntCap), "entry count beyond capacity")
    `BDQ_ASSERT(a_dump_nonempty, i_clk, i_rst_n, ((r_state != S_DUMP) || (r_count != '0)), "dump running on an empty queue")
    `BDQ_ASSERT_NEXT(a_dump_keeps_count, i_clk, i_rst_n, (r_state == S_DUMP), ($stable(r_count)), "dump changed the entry count")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the bounded double-ended queue with dump.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int unsigned CAPACITY = 32;
    localparam logic [OpW-1:0] OP_FIRST_UNUSED = OP_DUMP + 3'd1;
    localparam logic [OpW-1:0] OP_LAST_UNUSED  = 3'd7;
    localparam int unsigned MAX_GAP = 16;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned MAX_SHOWN = 10;

    typedef struct {
        logic signed [DataW-1:0] value;
        logic [StatusW-1:0]      status;
        logic                    last;
    } t_deque_reply;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [OpW-1:0]          i_operation = '0;
    logic signed [DataW-1:0] i_value = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [DataW-1:0] o_value_res;
    logic [StatusW-1:0]      o_status;
    logic                    o_last;

    // Shadow copy of the deque contents, kept as a ring buffer in front-to-back order.
    logic signed [DataW-1:0] shadow_entries [CAPACITY];
    int unsigned             shadow_front = 0;
    int unsigned             shadow_count = 0;
    t_deque_reply            awaited_replies [$];

    bit          sender_burst = 1'b0;
    bit          receiver_burst = 1'b0;
    logic        receiver_hold = 1'b0;
    int unsigned stall_left = 0;

    int unsigned fail_count = 0;
    int unsigned push_requests = 0;
    int unsigned pop_requests = 0;
    int unsigned dump_requests = 0;
    int unsigned dropped_requests = 0;
    int unsigned replies_checked = 0;
    int unsigned full_refusals = 0;
    int unsigned empty_reports = 0;
    int unsigned deepest_fill = 0;

    bounded_deque_with_dump #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_operation(i_operation),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_value_res(o_value_res),
        .o_status(o_status),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void await_reply(input logic signed [DataW-1:0] value,
                                        input logic [StatusW-1:0] status,
                                        input logic last);
        t_deque_reply r;
        r.value = value;
        r.status = status;
        r.last = last;
        awaited_replies.push_back(r);
        if (status == ST_FULL) full_refusals++;
        if (status == ST_EMPTY) empty_reports++;
    endfunction

    function automatic void predict_deque_op(input logic [OpW-1:0] op,
                                             input logic signed [DataW-1:0] val);
        int unsigned slot;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                push_requests++;
                if (shadow_count >= CAPACITY) begin
                    await_reply('0, ST_FULL, 1'b1);
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
                        slot = shadow_front;
                    end else begin
                        slot = (shadow_front + shadow_count) % CAPACITY;
                    end
                    shadow_entries[slot] = val;
                    shadow_count++;
                    if (shadow_count > deepest_fill) deepest_fill = shadow_count;
                    await_reply('0, ST_OK, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                pop_requests++;
                if (shadow_count == 0) begin
                    await_reply('0, ST_EMPTY, 1'b1);
                end else begin
                    if (op == OP_POP_FRONT) begin
                        slot = shadow_front;
                        shadow_front = (shadow_front + 1) % CAPACITY;
                    end else begin
                        slot = (shadow_front + shadow_count - 1) % CAPACITY;
                    end
                    shadow_count--;
                    await_reply(shadow_entries[slot], ST_OK, 1'b1);
                end
            end
            OP_DUMP: begin
                dump_requests++;
                if (shadow_count == 0) begin
                    await_reply('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < shadow_count; i++)
                        await_reply(shadow_entries[(shadow_front + i) % CAPACITY],
                                    ST_OK, i + 1 == shadow_count);
                end
            end
            default: begin
                dropped_requests++;
            end
        endcase
    endfunction

    // Offers one request and returns at the edge where the block takes it.
    // Valid stays high into the next request when that one has no gap.
    task automatic issue_request(input logic [OpW-1:0] op,
                                 input logic signed [DataW-1:0] val);
        int unsigned gap;
        gap = draw_gap(sender_burst);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_value <= val;
        do @(posedge i_clk); while (o_stall);
        predict_deque_op(op, val);
    endtask

    task automatic hold_output(input int unsigned cycles);
        receiver_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        receiver_hold <= 1'b0;
    endtask

    function automatic void check_reply();
        t_deque_reply exp;
        if (awaited_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
                $display("ERROR: unexpected reply value=%0d status=%0d last=%0d",
                         o_value_res, o_status, o_last);
            return;
        end
        exp = awaited_replies.pop_front();
        replies_checked++;
        if (o_value_res !== exp.value || o_status !== exp.status || o_last !== exp.last) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
                $display({"ERROR: reply %0d expected value=%0d status=%0d last=%0d,",
                          " got value=%0d status=%0d last=%0d"},
                         replies_checked, exp.value, exp.status, exp.last,
                         o_value_res, o_status, o_last);
        end
    endfunction

    // Takes replies and draws a new stall length after each one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                check_reply();
                stall_left = draw_gap(receiver_burst);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= receiver_hold;
            end
        end
    end

    function automatic logic [OpW-1:0] pick_operation(input int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) return OpW'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        if (r < 14) return OP_DUMP;
        if (r < 14 + push_pct * 86 / 100) return $urandom_range(0, 1) ? OP_PUSH_FRONT
                                                                     : OP_PUSH_BACK;
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    task automatic test_empty_queue();
        issue_request(OP_POP_FRONT, 32'sd5);
        issue_request(OP_POP_BACK, -32'sd5);
        issue_request(OP_DUMP, '0);
        for (int unsigned op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
            issue_request(OpW'(op), $signed($urandom()));
    endtask

    task automatic test_extreme_values();
        // The first front push wraps the ring position below zero.
        issue_request(OP_PUSH_FRONT, 32'sh8000_0000);
        issue_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
        issue_request(OP_PUSH_FRONT, -32'sd1);
        issue_request(OP_PUSH_BACK, '0);
        issue_request(OP_DUMP, -32'sd1);
        issue_request(OP_POP_BACK, '1);
        issue_request(OP_POP_FRONT, '1);
        issue_request(OP_DUMP, '0);
        issue_request(OP_POP_FRONT, '0);
        issue_request(OP_POP_BACK, '0);
        issue_request(OP_POP_BACK, '0);
    endtask

    task automatic test_full_under_backpressure();
        sender_burst = 1'b1;
        receiver_burst = 1'b1;
        fork
            hold_output(150);
            for (int unsigned i = 0; i < CAPACITY + 2; i++)
                issue_request($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                              $signed($urandom()));
        join
        sender_burst = 1'b0;
        receiver_burst = 1'b0;
        issue_request(OP_DUMP, $signed($urandom()));
        while (shadow_count > 0)
            issue_request($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                          $signed($urandom()));
        issue_request(OP_POP_FRONT, '0);
    endtask

    task automatic test_random_mix(input int unsigned count);
        int unsigned taken;
        logic [OpW-1:0] op;
        taken = 0;
        while (taken < count) begin
            // New idling pattern every fifteen requests; the push bias falls by thirds.
            if (taken % 15 == 0) begin
                sender_burst = $urandom_range(0, 2) == 0;
                receiver_burst = $urandom_range(0, 2) == 0;
            end
            op = pick_operation(taken < count / 3 ? 75 : (taken < 2 * count / 3 ? 50 : 25));
            issue_request(op, $signed($urandom()));
            if (op <= OP_DUMP) taken++;
        end
        sender_burst = 1'b0;
        receiver_burst = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_extreme_values();
        test_full_under_backpressure();
        test_random_mix(24);
        i_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (awaited_replies.size() != 0) fail_count++;
        $display("Summary: %0d pushes, %0d pops, %0d dumps, %0d dropped codes; %0d replies",
                 push_requests, pop_requests, dump_requests, dropped_requests,
                 replies_checked);
        $display("Summary: %0d full refusals, %0d empty reports, deepest fill %0d of %0d",
                 full_refusals, empty_reports, deepest_fill, CAPACITY);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d replies outstanding", awaited_replies.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
